@@ rtl/core/gsl_pkg.sv @@
// Shared types and constants for the grain scrub looper.
// Used by grain_scrub_looper_core and bench/tb.sv; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gsl_pkg;

	// Sample store depth; grain addresses wrap by truncation, so keep it a power of two.
	localparam int unsigned BUF_DEPTH = 32768;
	localparam int unsigned ADDR_W    = $clog2(BUF_DEPTH);
	// Write counter must hold BUF_DEPTH itself.
	localparam int unsigned CNT_W     = ADDR_W + 1;
	// Offset (15b) plus length (16b) needs 17 bits.
	localparam int unsigned CMP_W     = (CNT_W > 17) ? CNT_W : 17;
	// Signed grain position, -1 .. 65534.
	localparam int unsigned POS_W     = 17;
	localparam int unsigned SUM_W     = (ADDR_W > POS_W) ? ADDR_W : POS_W;

	localparam int unsigned SMP_W     = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 18;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_REC = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 3'd4;

	// Opcodes.
	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_START  = 2'd1;
	localparam logic [1:0] OP_STOP   = 2'd2;

	// Register reset values.
	localparam logic [15:0] MAX_REC_RST = 16'd32768;
	localparam logic [15:0] LENGTH_RST  = 16'd1024;
	localparam logic [17:0] RATE_RST    = 18'd65536;

	// Fade ramp length, and x/5 as (x * 52429) >> 18, exact for x < 2^18.
	localparam logic [15:0] FADE_LEN = 16'd20;
	localparam logic [15:0] DIV5_MUL = 16'd52429;
	localparam int unsigned DIV5_SH  = 18;

	typedef struct packed {
		logic [1:0]               opcode;
		logic signed [SMP_W-1:0]  sample_in;
	} gsl_in_t;

	typedef struct packed {
		logic signed [SMP_W-1:0]  sample_out;
		logic                     grain_playing;
	} gsl_out_t;

endpackage

`default_nettype wire

@@ rtl/core/gsl_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies. Read of an address written in the same cycle returns old data.
`timescale 1ns / 1ps
`default_nettype none

module gsl_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/grain_scrub_looper_core.sv @@
// Grain scrub looper: zero-crossing triggered recorder with faded grain loop playback.
// A sample's result passes the stage 1, stage 2 and output registers; events give none.
// Throughput: one item per cycle unless the output stalls; the store has a separate write
// and read port, so the sample write and the grain read of one item share a cycle.
// Reset: control state and registers return to defaults at once; the store is not cleared.
// Depends on gsl_pkg and gsl_ram.
`timescale 1ns / 1ps
`default_nettype none

module grain_scrub_looper_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [gsl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [gsl_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             req_valid,
	output logic                                  req_ready,
	input  wire gsl_pkg::gsl_in_t                 req,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_ready,
	output gsl_pkg::gsl_out_t                     rsp
);
	import gsl_pkg::*;

	// configuration registers
	logic [15:0]        max_rec_q;
	logic [14:0]        offset_cfg_q;
	logic [15:0]        length_cfg_q;
	logic [17:0]        rate_cfg_q;
	logic               reverse_cfg_q;

	// control state
	logic [CNT_W-1:0]   wp_q;
	logic [31:0]        phase_q;
	logic [SMP_W-1:0]   prev_q;
	logic               running_q;
	logic               crossing_q;
	logic               recording_q;
	logic               loaded_q;
	logic [14:0]        act_off_q;
	logic [15:0]        act_len_q;
	logic [17:0]        act_rate_q;
	logic               act_rev_q;

	// accept stage
	logic               accept;
	logic               is_sample;
	logic               is_start;
	logic [SMP_W-1:0]   x;
	logic               crossing_now;
	logic               rec_eff;
	logic [CNT_W-1:0]   wp_base;
	logic [CNT_W-1:0]   wp_inc;
	logic               load_hit;
	logic               limit_hit;
	logic               loaded_new;
	logic               play;
	logic               do_latch;
	logic [31:0]        phase_sum;
	logic [15:0]        ph;
	logic               wrap;
	logic [15:0]        len_left;
	logic [POS_W-1:0]   pos;
	logic [14:0]        off_sel;
	logic [15:0]        to_end;
	logic [15:0]        pos_f;
	logic [4:0]         k;
	logic               full;
	logic [SUM_W-1:0]   addr_sum;
	logic [ADDR_W-1:0]  raddr;
	logic [ADDR_W-1:0]  waddr;
	logic               we;
	logic               re;
	logic               fwd_now;
	logic [SMP_W-1:0]   rdata;

	// pipeline
	logic               v_s1;
	logic               play_s1;
	logic               fwd_s1;
	logic               full_s1;
	logic [4:0]         k_s1;
	logic [SMP_W-1:0]   x_s1;
	logic [SMP_W-1:0]   s_val;
	logic               s_neg;
	logic [SMP_W-1:0]   s_abs;
	logic [20:0]        prod;

	logic               v_s2;
	logic               mul_s2;
	logic               neg_s2;
	logic [20:0]        prod_s2;
	logic               play_s2;
	logic [SMP_W-1:0]   byp_s2;
	logic [34:0]        qprod;
	logic [15:0]        quot;
	logic [SMP_W-1:0]   y;

	logic               rsp_valid_q;
	gsl_out_t           rsp_q;
	logic               free_out;
	logic               free_s2;
	logic               free_s1;

	// ---------------- handshake ----------------
	assign free_out  = !rsp_valid_q || rsp_ready;
	assign free_s2   = !v_s2 || free_out;
	assign free_s1   = !v_s1 || free_s2;
	assign req_ready = free_s1;
	assign accept    = req_valid && free_s1;

	assign is_sample = (req.opcode == OP_SAMPLE);
	assign is_start  = (req.opcode == OP_START);
	assign x         = req.sample_in;

	// ---------------- record path ----------------
	assign crossing_now = running_q && !crossing_q && (x[SMP_W-1] != prev_q[SMP_W-1]);
	assign rec_eff      = running_q && (recording_q || crossing_now);
	assign wp_base      = crossing_now ? '0 : wp_q;
	assign wp_inc       = wp_base + CNT_W'(1);
	assign load_hit     = CMP_W'(wp_inc) >= (CMP_W'(act_off_q) + CMP_W'(act_len_q));
	assign limit_hit    = (CMP_W'(wp_inc) >= CMP_W'(max_rec_q)) ||
	                      (wp_inc >= CNT_W'(BUF_DEPTH));
	assign loaded_new   = loaded_q || (rec_eff && load_hit);
	assign play         = running_q && loaded_new;
	assign waddr        = wp_base[ADDR_W-1:0];

	// ---------------- grain position ----------------
	assign phase_sum = phase_q + 32'(act_rate_q);
	assign ph        = phase_sum[31:16];
	// both directions wrap once the integer phase reaches the length
	assign wrap      = (ph >= act_len_q);
	assign len_left  = act_len_q - ph;

	always_comb begin
		pos     = '0;
		off_sel = act_off_q;
		to_end  = len_left;
		pos_f   = ph;
		case ({act_rev_q, wrap})
			2'b00: begin
				pos    = POS_W'(ph);
				to_end = len_left;
				pos_f  = ph;
			end
			2'b01: begin
				pos     = '0;
				off_sel = offset_cfg_q;
				to_end  = length_cfg_q;
				pos_f   = '0;
			end
			2'b10: begin
				pos    = POS_W'(len_left - 16'd1);
				to_end = ph + 16'd1;
				pos_f  = len_left - 16'd1;
			end
			2'b11: begin
				// restarts at the far end of the newly latched grain (-1 for length 0)
				pos     = POS_W'(length_cfg_q) - POS_W'(1);
				off_sel = offset_cfg_q;
				to_end  = 16'd1;
				pos_f   = '0;
			end
			default: begin
				pos = '0;
			end
		endcase
	end

	always_comb begin
		full = 1'b0;
		k    = '0;
		if (to_end < FADE_LEN) begin
			k = to_end[4:0];
		end else if (pos_f < FADE_LEN) begin
			k = pos_f[4:0];
		end else begin
			full = 1'b1;
		end
	end

	assign addr_sum = SUM_W'(off_sel) + SUM_W'($signed(pos));
	assign raddr    = addr_sum[ADDR_W-1:0];

	assign we       = accept && is_sample && rec_eff;
	assign re       = accept && is_sample && play;
	// same-cycle read of the entry being written: take the incoming sample
	assign fwd_now  = rec_eff && (raddr == waddr);
	assign do_latch = accept && ((is_start && !running_q) ||
	                             (is_sample && play && wrap));

	gsl_ram #(
		.WIDTH(SMP_W),
		.DEPTH(BUF_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (x),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rec_q     <= MAX_REC_RST;
			offset_cfg_q  <= '0;
			length_cfg_q  <= LENGTH_RST;
			rate_cfg_q    <= RATE_RST;
			reverse_cfg_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_REC: max_rec_q     <= cfg_data[15:0];
				REG_OFFSET:  offset_cfg_q  <= cfg_data[14:0];
				REG_LENGTH:  length_cfg_q  <= cfg_data[15:0];
				REG_RATE:    rate_cfg_q    <= cfg_data[17:0];
				REG_REVERSE: reverse_cfg_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_off_q  <= '0;
			act_len_q  <= '0;
			act_rate_q <= RATE_RST;
			act_rev_q  <= 1'b0;
		end else if (do_latch) begin
			act_off_q  <= offset_cfg_q;
			act_len_q  <= length_cfg_q;
			act_rate_q <= rate_cfg_q;
			act_rev_q  <= reverse_cfg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			phase_q     <= '0;
			prev_q      <= '0;
			running_q   <= 1'b0;
			crossing_q  <= 1'b0;
			recording_q <= 1'b0;
			loaded_q    <= 1'b0;
		end else if (accept) begin
			case (req.opcode)
				OP_START: begin
					if (!running_q) begin
						running_q   <= 1'b1;
						crossing_q  <= 1'b0;
						recording_q <= 1'b0;
						loaded_q    <= 1'b0;
					end
				end
				OP_STOP: begin
					running_q   <= 1'b0;
					crossing_q  <= 1'b0;
					recording_q <= 1'b0;
					loaded_q    <= 1'b0;
				end
				OP_SAMPLE: begin
					if (!running_q) begin
						prev_q <= x;
					end else begin
						if (crossing_now) begin
							crossing_q <= 1'b1;
						end else if (!crossing_q) begin
							prev_q <= x;
						end
						if (rec_eff) begin
							wp_q        <= wp_inc;
							loaded_q    <= loaded_new;
							recording_q <= !limit_hit;
						end
						if (play) begin
							phase_q <= wrap ? '0 : phase_sum;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// stage 1: store data arrives, take magnitude and scale by fade step
	assign s_val = fwd_s1 ? x_s1 : rdata;
	assign s_neg = s_val[SMP_W-1];
	assign s_abs = s_neg ? (SMP_W'(0) - s_val) : s_val;
	assign prod  = 21'(s_abs) * 21'(k_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (free_s1) begin
			v_s1 <= accept && is_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			play_s1 <= play;
			fwd_s1  <= fwd_now;
			full_s1 <= full;
			k_s1    <= k;
			x_s1    <= x;
		end
	end

	// stage 2: for faded grain samples divide magnitude by 20 as (p >> 2) / 5, then restore sign
	assign qprod = 35'(prod_s2[20:2]) * 35'(DIV5_MUL);
	assign quot  = qprod[DIV5_SH +: 16];
	assign y     = mul_s2 ? (neg_s2 ? (16'd0 - quot) : quot) : byp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (free_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && free_s2) begin
			play_s2 <= play_s1;
			mul_s2  <= play_s1 && !full_s1;
			neg_s2  <= s_neg;
			prod_s2 <= prod;
			byp_s2  <= play_s1 ? s_val : x_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (free_out) begin
			rsp_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && free_out) begin
			rsp_q.sample_out    <= y;
			rsp_q.grain_playing <= play_s2;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_rec_running: assert property (@(posedge clk) disable iff (!arst_n)
		recording_q |-> (running_q && crossing_q))
		else $error("recording outside a running, triggered pass");

	a_loaded_running: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q |-> (running_q && crossing_q))
		else $error("loaded outside a running, triggered pass");

	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		recording_q |-> (wp_q < CNT_W'(BUF_DEPTH)))
		else $error("recording with write pointer past store");

	a_fwd_item: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_sample && play && fwd_now) |=> (v_s1 && play_s1 && fwd_s1))
		else $error("forwarded read lost its item");
`endif

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for grain_scrub_looper_core: grain record/loop/fade behavior
// against an in-bench predictor, with random valid/ready idling on both channels.
// Depends on gsl_pkg and the core RTL.
`timescale 1ns / 1ps

import gsl_pkg::*;

localparam int RAMP = 20;
localparam int STORE_DEPTH = int'(BUF_DEPTH);

typedef struct {
	int unsigned  wr_count;
	int           play_idx;
	bit [31:0]    phase;
	logic signed [15:0] last_in;
	bit           running;
	bit           crossed;
	bit           recording;
	bit           loaded;
	bit [14:0]    g_offset;
	bit [15:0]    g_length;
	bit [17:0]    g_rate;
	bit           g_rev;
} loop_state_t;

class grain_loop_scoreboard;
	logic signed [15:0] store [STORE_DEPTH];
	bit filled [STORE_DEPTH];
	bit [15:0] rec_limit;
	bit [14:0] offset_reg;
	bit [15:0] length_reg;
	bit [17:0] rate_reg;
	bit rev_reg;
	loop_state_t st;
	gsl_out_t expected_q[$];
	int errors;
	int results;
	int played;

	function new();
		rec_limit = MAX_REC_RST;
		offset_reg = '0;
		length_reg = LENGTH_RST;
		rate_reg = RATE_RST;
		rev_reg = 1'b0;
		st = '{default: 0};
		st.g_rate = RATE_RST;
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		case (idx)
		REG_MAX_REC: rec_limit = value[15:0];
		REG_OFFSET:  offset_reg = value[14:0];
		REG_LENGTH:  length_reg = value[15:0];
		REG_RATE:    rate_reg = value[17:0];
		REG_REVERSE: rev_reg = value[0];
		default: ;
		endcase
	endfunction

	function void latch(inout loop_state_t s);
		s.g_offset = offset_reg;
		s.g_length = length_reg;
		s.g_rate = rate_reg;
		s.g_rev = rev_reg;
	endfunction

	// One item through the grain looper. With commit low the store is left alone and
	// blank reports whether the grain read would hit a never-written entry.
	function bit advance(inout loop_state_t s, input gsl_in_t item, input bit commit,
			output gsl_out_t res, output bit blank);
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] word;
		int unsigned cap;
		int wr_at;
		int ph;
		int len;
		int addr;
		int smp;
		int to_end;
		int q;
		x = item.sample_in;
		y = x;
		blank = 1'b0;
		wr_at = -1;
		res = '0;
		case (item.opcode)
		OP_START: begin
			if (!s.running) begin
				s.loaded = 1'b0;
				s.recording = 1'b0;
				s.crossed = 1'b0;
				s.running = 1'b1;
				latch(s);
			end
			return 1'b0;
		end
		OP_STOP: begin
			s.running = 1'b0;
			s.crossed = 1'b0;
			s.loaded = 1'b0;
			s.recording = 1'b0;
			return 1'b0;
		end
		OP_SAMPLE: ;
		default: return 1'b0;
		endcase

		if (!s.running) begin
			s.last_in = x;
		end else begin
			if (!s.crossed) begin
				// sign change against the last sample arms the recorder
				if (x[15] != s.last_in[15]) begin
					s.recording = 1'b1;
					s.wr_count = 0;
					s.play_idx = 0;
					s.crossed = 1'b1;
				end else begin
					s.last_in = x;
				end
			end
			if (s.recording) begin
				cap = (rec_limit > BUF_DEPTH) ? BUF_DEPTH : rec_limit;
				if (s.wr_count < BUF_DEPTH) begin
					wr_at = s.wr_count;
					if (commit) begin
						store[wr_at] = x;
						filled[wr_at] = 1'b1;
					end
				end
				s.wr_count++;
				if (s.wr_count >= 32'(s.g_offset) + 32'(s.g_length))
					s.loaded = 1'b1;
				if (s.wr_count >= cap)
					s.recording = 1'b0;
			end
			if (s.loaded) begin
				s.phase = s.phase + 32'(s.g_rate);
				ph = int'(s.phase[31:16]);
				len = int'(s.g_length);
				if (!s.g_rev) begin
					s.play_idx = ph;
					if (s.play_idx >= len) begin
						s.phase = '0;
						s.play_idx = 0;
						latch(s);
					end
				end else begin
					s.play_idx = len - ph - 1;
					if (s.play_idx < 0 || s.play_idx >= len) begin
						s.phase = '0;
						latch(s);
						s.play_idx = int'(s.g_length) - 1;
					end
				end
				addr = (int'(s.g_offset) + s.play_idx) % STORE_DEPTH;
				if (addr < 0)
					addr += STORE_DEPTH;
				if (addr == wr_at) begin
					word = x;
				end else begin
					word = store[addr];
					blank = !filled[addr];
				end
				smp = word;
				to_end = int'(s.g_length) - s.play_idx;
				if (to_end < RAMP)
					q = (smp * to_end) / RAMP;
				else if (s.play_idx < RAMP)
					q = (smp * s.play_idx) / RAMP;
				else
					q = smp;
				y = q[15:0];
				res.grain_playing = 1'b1;
			end
		end
		res.sample_out = y;
		return 1'b1;
	endfunction

	function bit reads_blank(gsl_in_t item);
		loop_state_t trial;
		gsl_out_t scratch;
		bit blank;
		trial = st;
		void'(advance(trial, item, 1'b0, scratch, blank));
		return blank;
	endfunction

	function void note_input(gsl_in_t item);
		gsl_out_t res;
		bit blank;
		if (advance(st, item, 1'b1, res, blank))
			expected_q.push_back(res);
	endfunction

	function void check_result(gsl_out_t got);
		gsl_out_t want;
		if (expected_q.size() == 0) begin
			errors++;
			if (errors <= 50)
				$error("unexpected result: sample_out %0d grain_playing %0b",
					got.sample_out, got.grain_playing);
			return;
		end
		want = expected_q.pop_front();
		results++;
		if (want.grain_playing)
			played++;
		if (got.sample_out !== want.sample_out) begin
			errors++;
			if (errors <= 50)
				$error("sample_out: expected %0d, got %0d", want.sample_out, got.sample_out);
		end
		if (got.grain_playing !== want.grain_playing) begin
			errors++;
			if (errors <= 50)
				$error("grain_playing: expected %0b, got %0b",
					want.grain_playing, got.grain_playing);
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module tb;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE = 8;
	localparam int RAND_ITEMS = 500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_ready;
	gsl_in_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	gsl_out_t rsp;

	grain_loop_scoreboard sb;
	int idle_pct = 19;
	int stim_count = 0;
	int noise_count = 0;
	int setups = 0;
	int quiet_cycles = 0;

	grain_scrub_looper_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			sb.check_result(rsp);
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	function automatic int rand_sample();
		case ($urandom_range(3))
		0: return int'($urandom_range(0, 64)) - 32;
		1: return $urandom_range(1) ? 32767 : -32768;
		default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// A sample whose grain read would land on a never-written entry goes out as a stop.
	task automatic send(input logic [1:0] op, input int val);
		gsl_in_t it;
		it.opcode = op;
		it.sample_in = val[15:0];
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		if (it.opcode == OP_SAMPLE && sb.reads_blank(it))
			it.opcode = OP_STOP;
		req <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.note_input(it);
		if (it.opcode == OP_UNUSED)
			noise_count++;
		else
			stim_count++;
	endtask

	// Hold the sender until every result is back, then let the pipeline settle.
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.set_reg(idx, value);
	endtask

	task automatic apply_setup(input int unsigned rec, input int unsigned off,
			input int unsigned len, input int unsigned rate, input int unsigned rev);
		write_reg(REG_MAX_REC, rec);
		write_reg(REG_OFFSET, off);
		write_reg(REG_LENGTH, len);
		write_reg(REG_RATE, rate);
		write_reg(REG_REVERSE, rev);
		setups++;
	endtask

	// First few setups pin the corner settings; the rest are random small grains.
	task automatic random_setup(input int kind);
		int unsigned off;
		int unsigned len;
		int unsigned rec;
		int unsigned rate;
		int unsigned rev;
		off = $urandom_range(0, 40);
		len = $urandom_range(1, 48);
		if ($urandom_range(9) < 7)
			rec = $urandom_range(off + len, 32768);
		else
			rec = $urandom_range(1, off + len);
		case ($urandom_range(4))
		0: rate = 0;
		1: rate = 262143;
		2: rate = 65536;
		3: rate = $urandom_range(0, 262143);
		default: rate = $urandom_range(16384, 98304);
		endcase
		rev = $urandom_range(1);
		case (kind)
		0: begin
			len = 0;
			rev = 1;
		end
		1: begin
			len = 0;
			rev = 0;
		end
		2: rec = 1;
		3: rate = 0;
		4: begin
			rate = 262143;
			rev = 1;
		end
		default: ;
		endcase
		apply_setup(rec, off, len, rate, rev);
	endtask

	// Start (if stopped), record through the crossing, play, with some stray items mixed in.
	task automatic run_session(input int plays, input bit stop_after);
		int n;
		int r;
		if (!sb.st.running)
			send(OP_START, rand_sample());
		n = sb.st.loaded ? plays : int'(sb.st.g_offset) + int'(sb.st.g_length) + 4 + plays;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 3) begin
				send(OP_UNUSED, rand_sample());
			end else if (r < 5) begin
				send(OP_START, rand_sample());
			end else if (r == 5) begin
				send(OP_STOP, rand_sample());
				send(OP_START, rand_sample());
			end
			send(OP_SAMPLE, rand_sample());
		end
		if (stop_after)
			send(OP_STOP, rand_sample());
	endtask

	initial begin
		int run_vals[] = '{5, -1, 32767, -32768, 7, -7, 100, -200, 300, 0, -1, 2};
		int base;
		int kind;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: passthrough extremes, ignored opcode, events, crossing, record limit,
		// short fully faded grain with forward wraps
		apply_setup(8, 2, 3, 65536, 0);
		send(OP_SAMPLE, 32767);
		send(OP_SAMPLE, -32768);
		send(OP_UNUSED, 'h1234);
		send(OP_STOP, 0);
		send(OP_SAMPLE, 0);
		send(OP_START, 0);
		send(OP_START, -1);
		foreach (run_vals[i])
			send(OP_SAMPLE, run_vals[i]);
		send(OP_STOP, 0);
		send(OP_SAMPLE, 9);
		drain();

		// larger offset recorded without idling, then a longer reverse grain at top rate
		idle_pct = 0;
		apply_setup(32768, 100, 60, 262143, 0);
		send(OP_START, 0);
		send(OP_SAMPLE, 1);
		send(OP_SAMPLE, -1);
		while (!sb.st.loaded)
			send(OP_SAMPLE, rand_sample());
		idle_pct = 19;
		repeat (40) send(OP_SAMPLE, rand_sample());
		drain();
		apply_setup(32768, 0, 160, 262143, 1);
		repeat (60) send(OP_SAMPLE, rand_sample());
		send(OP_STOP, 0);

		base = stim_count;
		kind = 0;
		while (stim_count - base < RAND_ITEMS) begin
			drain();
			random_setup(kind);
			run_session($urandom_range(8, 60), $urandom_range(9) < 6);
			kind++;
		end

		drain();
		if (sb.pending() != 0)
			$error("%0d expected results never arrived", sb.pending());
		$display("sent %0d items (+%0d unused-opcode), checked %0d results, %0d from grains",
			stim_count, noise_count, sb.results, sb.played);
		$display("%0d register setups incl. zero-length, reverse, rate and record-limit corners",
			setups);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule

@@ grain_scrub_looper_core.f @@
rtl/core/gsl_pkg.sv
rtl/core/gsl_ram.sv
rtl/core/grain_scrub_looper_core.sv
bench/tb.sv
